### hw/rtl/fgr_pkg.sv
// Package: sizes, register codes and shared types of the FFT grid resize remap unit.
package fgr_pkg;

  localparam int MAX_GRID_DIM = 256;

  localparam int POS_W  = $clog2(MAX_GRID_DIM);
  localparam int SZ_W   = $clog2(MAX_GRID_DIM + 1);
  localparam int PART_W = SZ_W + POS_W;
  localparam int CFG_W  = 9;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_W = 64;
  localparam int IDX_W  = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_X = 3'd0,
    REG_SRC_Y = 3'd1,
    REG_SRC_Z = 3'd2,
    REG_DST_X = 3'd3,
    REG_DST_Y = 3'd4,
    REG_DST_Z = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic             keep;
    logic             last;
    logic [POS_W-1:0] coord;
  } axis_map_t;

  typedef struct packed {
    logic              we;
    logic              done;
    logic [POS_W-1:0]  cx;
    logic [POS_W-1:0]  cy;
    logic [POS_W-1:0]  cz;
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
  } item_t;

endpackage

### hw/rtl/fgr_in_if.sv
// Interface: source sample channel with valid/ready handshake.
interface fgr_in_if;
  logic                      valid;
  logic                      ready;
  logic [fgr_pkg::DATA_W-1:0] sample_real;
  logic [fgr_pkg::DATA_W-1:0] sample_imag;

  modport source(output valid, output sample_real, output sample_imag, input ready);
  modport sink(input valid, input sample_real, input sample_imag, output ready);
endinterface

### hw/rtl/fgr_out_if.sv
// Interface: remapped result channel with valid/ready handshake.
interface fgr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      write_enable;
  logic [fgr_pkg::IDX_W-1:0]  dest_index;
  logic [fgr_pkg::DATA_W-1:0] out_real;
  logic [fgr_pkg::DATA_W-1:0] out_imag;
  logic                      grid_done;

  modport source(output valid, output write_enable, output dest_index, output out_real,
                 output out_imag, output grid_done, input ready);
  modport sink(input valid, input write_enable, input dest_index, input out_real,
               input out_imag, input grid_done, output ready);
endinterface

### hw/rtl/fgr_axis_map.sv
// Per-axis coordinate map: keep/drop decision, destination coordinate and wrap flag.
module fgr_axis_map (
  input  logic [fgr_pkg::POS_W-1:0] pos_i,
  input  logic [fgr_pkg::SZ_W-1:0]  src_size_i,
  input  logic [fgr_pkg::SZ_W-1:0]  dst_size_i,
  output fgr_pkg::axis_map_t        map_o
);

  localparam int W = fgr_pkg::SZ_W + 1;

  logic [W-1:0] pos_ext;
  logic [W-1:0] src_ext;
  logic [W-1:0] dst_ext;
  logic [W-1:0] n_min;
  logic [W-1:0] half;
  logic [W-1:0] hi_start;
  logic [W-1:0] hi_coord;
  logic         in_range;
  logic         keep_lo;
  logic         keep_hi;

  assign pos_ext  = W'(pos_i);
  assign src_ext  = W'(src_size_i);
  assign dst_ext  = W'(dst_size_i);
  assign n_min    = (src_ext < dst_ext) ? src_ext : dst_ext;
  assign half     = n_min >> 1;
  assign hi_start = src_ext - (n_min - half);
  assign hi_coord = pos_ext + dst_ext - src_ext;
  assign in_range = pos_ext < src_ext;
  assign keep_lo  = in_range && (pos_ext < half);
  assign keep_hi  = in_range && (pos_ext >= hi_start);

  always_comb begin
    map_o.keep  = keep_lo || keep_hi;
    map_o.last  = (pos_ext + W'(1)) >= src_ext;
    map_o.coord = keep_lo ? pos_i : fgr_pkg::POS_W'(hi_coord);
  end

endmodule

### hw/rtl/fgr_index_pipe.sv
// Index pipeline: two multiply stages that form the linear destination index.
module fgr_index_pipe (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s1_valid_i,
  output logic                     s1_ready_o,
  input  fgr_pkg::item_t           s1_item_i,
  input  logic [fgr_pkg::SZ_W-1:0] dst_size_x_i,
  input  logic [fgr_pkg::SZ_W-1:0] dst_size_y_i,
  fgr_out_if.source                out_ch
);

  localparam int PROD_W = fgr_pkg::SZ_W + fgr_pkg::PART_W;

  logic                          s2_valid_q;
  fgr_pkg::item_t                s2_item_q;
  logic [fgr_pkg::PART_W-1:0]    s2_part_q;
  logic [fgr_pkg::PART_W-1:0]    s2_part_d;
  logic                          s2_ready;

  logic                          s3_valid_q;
  logic                          s3_we_q;
  logic                          s3_done_q;
  logic [fgr_pkg::IDX_W-1:0]     s3_idx_q;
  logic [fgr_pkg::IDX_W-1:0]     s3_idx_d;
  logic [fgr_pkg::DATA_W-1:0]    s3_re_q;
  logic [fgr_pkg::DATA_W-1:0]    s3_im_q;
  logic                          s3_ready;
  logic [PROD_W-1:0]             full_idx;

  assign s3_ready   = !s3_valid_q || out_ch.ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready_o = s2_ready;

  // row index across all planes: cy + dy * cz
  assign s2_part_d = fgr_pkg::PART_W'(s1_item_i.cy) + dst_size_y_i * s1_item_i.cz;

  assign full_idx = PROD_W'(s2_item_q.cx) + dst_size_x_i * s2_part_q;
  assign s3_idx_d = s2_item_q.we ? fgr_pkg::IDX_W'(full_idx) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_q <= s1_valid_i;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_i) begin
      s2_item_q <= s1_item_i;
      s2_part_q <= s2_part_d;
    end
    if (s3_ready && s2_valid_q) begin
      s3_we_q   <= s2_item_q.we;
      s3_done_q <= s2_item_q.done;
      s3_idx_q  <= s3_idx_d;
      s3_re_q   <= s2_item_q.re;
      s3_im_q   <= s2_item_q.im;
    end
  end

  assign out_ch.valid        = s3_valid_q;
  assign out_ch.write_enable = s3_we_q;
  assign out_ch.grid_done    = s3_done_q;
  assign out_ch.dest_index   = s3_idx_q;
  assign out_ch.out_real     = s3_re_q;
  assign out_ch.out_imag     = s3_im_q;

  a_drop_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !s3_we_q |-> s3_idx_q == '0)
    else $error("dropped sample carries nonzero index");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !out_ch.ready |=> s3_valid_q && $stable(s3_idx_q))
    else $error("stalled result lost or changed");

  a_stall_holds_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !out_ch.ready |=> $stable(s3_re_q) && $stable(s3_im_q) &&
    $stable(s3_we_q) && $stable(s3_done_q))
    else $error("stalled result data changed");

endmodule

### hw/rtl/fft_grid_resize_remap_unit.sv
// Top level: FFT grid resize remap unit with config registers, counters and input stage.
//
// Usage: source samples of one 3D grid enter on in_ch in raster order, x fastest.
// Each transfer yields exactly one result on out_ch: a write flag, the linear
// destination index (zero when dropped), both data words unchanged, and a flag
// on the last sample of the grid.
// Pipeline: a result passes the input register, the row offset multiply and the plane
// index multiply before it is valid on out_ch.
// Throughput: one sample per cycle while out_ch.ready is high; the x, y and z position
// counters advance on each input transfer, and the two multiplies sit in separate stages.
// Configuration: cfg_we_i writes register cfg_idx_i (source sizes x/y/z, then
// destination sizes x/y/z); write only while no sample is in flight.
// Reset: all sizes return to 1, counters to 0, the pipeline empties.
// Stall: when out_ch.ready is low, the result holds and the stages fill; in_ch
// keeps taking samples until all three stages are full, then ready drops.
module fft_grid_resize_remap_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fgr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fgr_pkg::CFG_W-1:0]     cfg_wdata_i,
  fgr_in_if.sink                        in_ch,
  fgr_out_if.source                     out_ch
);

  logic [fgr_pkg::CFG_W-1:0] src_x_q, src_y_q, src_z_q;
  logic [fgr_pkg::CFG_W-1:0] dst_x_q, dst_y_q, dst_z_q;
  logic [fgr_pkg::SZ_W-1:0]  eff_src_x, eff_src_y, eff_src_z;
  logic [fgr_pkg::SZ_W-1:0]  eff_dst_x, eff_dst_y, eff_dst_z;

  logic [fgr_pkg::POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [fgr_pkg::POS_W-1:0] pos_x_d, pos_y_d, pos_z_d;

  fgr_pkg::axis_map_t map_x, map_y, map_z;

  logic           s1_valid_q;
  fgr_pkg::item_t s1_item_q;
  fgr_pkg::item_t s1_item_d;
  logic           s1_ready;
  logic           s1_ready_pipe;
  logic           in_xfer;

  function automatic logic [fgr_pkg::SZ_W-1:0] eff_size(input logic [fgr_pkg::CFG_W-1:0] v);
    logic [fgr_pkg::SZ_W-1:0] r;
    if (v == '0) begin
      r = fgr_pkg::SZ_W'(1);
    end else if (32'(v) > 32'(fgr_pkg::MAX_GRID_DIM)) begin
      r = fgr_pkg::SZ_W'(fgr_pkg::MAX_GRID_DIM);
    end else begin
      r = fgr_pkg::SZ_W'(v);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_x_q <= fgr_pkg::CFG_W'(1);
      src_y_q <= fgr_pkg::CFG_W'(1);
      src_z_q <= fgr_pkg::CFG_W'(1);
      dst_x_q <= fgr_pkg::CFG_W'(1);
      dst_y_q <= fgr_pkg::CFG_W'(1);
      dst_z_q <= fgr_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (fgr_pkg::cfg_reg_e'(cfg_idx_i))
        fgr_pkg::REG_SRC_X: src_x_q <= cfg_wdata_i;
        fgr_pkg::REG_SRC_Y: src_y_q <= cfg_wdata_i;
        fgr_pkg::REG_SRC_Z: src_z_q <= cfg_wdata_i;
        fgr_pkg::REG_DST_X: dst_x_q <= cfg_wdata_i;
        fgr_pkg::REG_DST_Y: dst_y_q <= cfg_wdata_i;
        fgr_pkg::REG_DST_Z: dst_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign eff_src_x = eff_size(src_x_q);
  assign eff_src_y = eff_size(src_y_q);
  assign eff_src_z = eff_size(src_z_q);
  assign eff_dst_x = eff_size(dst_x_q);
  assign eff_dst_y = eff_size(dst_y_q);
  assign eff_dst_z = eff_size(dst_z_q);

  fgr_axis_map u_map_x (.pos_i(pos_x_q), .src_size_i(eff_src_x), .dst_size_i(eff_dst_x),
                        .map_o(map_x));
  fgr_axis_map u_map_y (.pos_i(pos_y_q), .src_size_i(eff_src_y), .dst_size_i(eff_dst_y),
                        .map_o(map_y));
  fgr_axis_map u_map_z (.pos_i(pos_z_q), .src_size_i(eff_src_z), .dst_size_i(eff_dst_z),
                        .map_o(map_z));

  assign s1_ready    = s1_ready_pipe;
  assign in_ch.ready = !s1_valid_q || s1_ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // advance raster position, x fastest
  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    if (!map_x.last) begin
      pos_x_d = pos_x_q + fgr_pkg::POS_W'(1);
    end else begin
      pos_x_d = '0;
      if (!map_y.last) begin
        pos_y_d = pos_y_q + fgr_pkg::POS_W'(1);
      end else begin
        pos_y_d = '0;
        pos_z_d = map_z.last ? '0 : pos_z_q + fgr_pkg::POS_W'(1);
      end
    end
  end

  always_comb begin
    s1_item_d.we   = map_x.keep && map_y.keep && map_z.keep;
    s1_item_d.done = map_x.last && map_y.last && map_z.last;
    s1_item_d.cx   = map_x.coord;
    s1_item_d.cy   = map_y.coord;
    s1_item_d.cz   = map_z.coord;
    s1_item_d.re   = in_ch.sample_real;
    s1_item_d.im   = in_ch.sample_imag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q    <= '0;
      pos_y_q    <= '0;
      pos_z_q    <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
        pos_z_q <= pos_z_d;
      end
      if (in_ch.ready) begin
        s1_valid_q <= in_ch.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= s1_item_d;
    end
  end

  fgr_index_pipe u_index_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid_q),
    .s1_ready_o   (s1_ready_pipe),
    .s1_item_i    (s1_item_q),
    .dst_size_x_i (eff_dst_x),
    .dst_size_y_i (eff_dst_y),
    .out_ch       (out_ch)
  );

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(pos_x_q) && $stable(pos_y_q) && $stable(pos_z_q))
    else $error("position moved without a transfer");

  a_grid_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s1_item_d.done |=> pos_x_q == '0 && pos_y_q == '0 && pos_z_q == '0)
    else $error("position did not wrap at end of grid");

  a_x_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !map_x.last |=> pos_x_q == $past(pos_x_q) + fgr_pkg::POS_W'(1))
    else $error("x position did not advance");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_ready |=> s1_valid_q)
    else $error("input stage dropped a stalled sample");

endmodule

### tb/tb_top.sv
// Testbench for the FFT grid resize remap unit: streams samples, predicts each remap, checks results.
module tb_top;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_AT = 100;
  localparam int HOLD_LEN = 120;
  localparam int TOTAL_ITEMS = 1300;
  localparam int CALM_ITEMS = 1100;
  localparam logic [fgr_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [fgr_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [fgr_pkg::DATA_W-1:0] re;
    logic [fgr_pkg::DATA_W-1:0] im;
  } sample_t;

  typedef struct packed {
    logic                       we;
    logic [fgr_pkg::IDX_W-1:0]  idx;
    logic [fgr_pkg::DATA_W-1:0] re;
    logic [fgr_pkg::DATA_W-1:0] im;
    logic                       done;
  } remap_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i;
  logic [fgr_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [fgr_pkg::CFG_W-1:0]     cfg_wdata_i;

  fgr_in_if  in_ch ();
  fgr_out_if out_ch ();

  fft_grid_resize_remap_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #2 clk_i = ~clk_i;

  sample_t       source_samples[$];
  remap_result_t remap_queue[$];
  sample_t       next_sample;
  remap_result_t want;

  logic [fgr_pkg::CFG_W-1:0] size_reg [6];
  logic [fgr_pkg::POS_W-1:0] pos_x, pos_y, pos_z;

  int  err_cnt = 0;
  int  sent_cnt;
  int  recv_cnt;
  int  gap_cnt;
  int  stall_cnt;
  int  hold_cnt;
  bit  hold_done;
  bit  calm;
  int  cycle_cnt = 0;

  function automatic int eff_dim(logic [fgr_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > fgr_pkg::MAX_GRID_DIM) return fgr_pkg::MAX_GRID_DIM;
    return int'(v);
  endfunction

  function automatic bit map_coord(int s, int src, int dst, output int d);
    int n, h;
    n = (src < dst) ? src : dst;
    h = n / 2;
    d = 0;
    if (s >= src) return 1'b0;
    if (s < h) begin
      d = s;
      return 1'b1;
    end
    if (s >= src - (n - h)) begin
      d = s + dst - src;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic remap_result_t remap_sample(logic [fgr_pkg::DATA_W-1:0] re,
                                                 logic [fgr_pkg::DATA_W-1:0] im);
    remap_result_t r;
    int sx, sy, sz, dx, dy, dz, cx, cy, cz, full;
    bit kx, ky, kz, lx, ly, lz;
    sx = eff_dim(size_reg[fgr_pkg::REG_SRC_X]);
    sy = eff_dim(size_reg[fgr_pkg::REG_SRC_Y]);
    sz = eff_dim(size_reg[fgr_pkg::REG_SRC_Z]);
    dx = eff_dim(size_reg[fgr_pkg::REG_DST_X]);
    dy = eff_dim(size_reg[fgr_pkg::REG_DST_Y]);
    dz = eff_dim(size_reg[fgr_pkg::REG_DST_Z]);
    kx = map_coord(int'(pos_x), sx, dx, cx);
    ky = map_coord(int'(pos_y), sy, dy, cy);
    kz = map_coord(int'(pos_z), sz, dz, cz);
    lx = (int'(pos_x) + 1 >= sx);
    ly = (int'(pos_y) + 1 >= sy);
    lz = (int'(pos_z) + 1 >= sz);
    r.we = kx && ky && kz;
    full = r.we ? cx + dx * (cy + dy * cz) : 0;
    r.idx = full[fgr_pkg::IDX_W-1:0];
    r.re = re;
    r.im = im;
    r.done = lx && ly && lz;
    if (!lx) begin
      pos_x = pos_x + 1'b1;
    end else begin
      pos_x = '0;
      if (!ly) begin
        pos_y = pos_y + 1'b1;
      end else begin
        pos_y = '0;
        if (!lz) pos_z = pos_z + 1'b1;
        else pos_z = '0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [fgr_pkg::DATA_W-1:0] got,
                                 logic [fgr_pkg::DATA_W-1:0] exp_v);
    $display("tb_top: mismatch on %s at result %0d: got %h, wanted %h",
             field, recv_cnt, got, exp_v);
    err_cnt++;
  endtask

  task automatic write_reg(logic [fgr_pkg::CFG_IDX_W-1:0] idx, logic [fgr_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx < 6) size_reg[idx] = val;
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_sample(logic [fgr_pkg::DATA_W-1:0] re, logic [fgr_pkg::DATA_W-1:0] im);
    sample_t s;
    s.re = re;
    s.im = im;
    source_samples.push_back(s);
  endtask

  function automatic logic [fgr_pkg::DATA_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic push_items(int count);
    repeat (count) push_sample(rand_word(), rand_word());
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (source_samples.size() != 0 || in_ch.valid || remap_queue.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  function automatic logic [fgr_pkg::CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return fgr_pkg::CFG_W'($urandom_range(257, 511));
    if (r == 2) return fgr_pkg::CFG_W'(fgr_pkg::MAX_GRID_DIM);
    if (r < 5) return fgr_pkg::CFG_W'($urandom_range(7, 16));
    return fgr_pkg::CFG_W'($urandom_range(1, 6));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.sample_real <= '0;
      in_ch.sample_imag <= '0;
      gap_cnt           <= 0;
      sent_cnt          <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        remap_queue.push_back(remap_sample(in_ch.sample_real, in_ch.sample_imag));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_cnt != 0) begin
          gap_cnt     <= gap_cnt - 1;
          in_ch.valid <= 1'b0;
        end else if (source_samples.size() != 0) begin
          next_sample = source_samples.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.sample_real <= next_sample.re;
          in_ch.sample_imag <= next_sample.im;
          if (!calm && $urandom_range(0, 5) == 0) gap_cnt <= $urandom_range(1, 6);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // hold off the receiver once so the pipeline fills and stalls the sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_cnt >= HOLD_AT) begin
      hold_cnt  <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_cnt    <= 0;
      recv_cnt     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (remap_queue.size() == 0) begin
          report_mismatch("unexpected result", out_ch.out_real, '0);
        end else begin
          want = remap_queue.pop_front();
          if (out_ch.write_enable !== want.we)
            report_mismatch("write_enable", fgr_pkg::DATA_W'(out_ch.write_enable),
                            fgr_pkg::DATA_W'(want.we));
          if (out_ch.dest_index !== want.idx)
            report_mismatch("dest_index", fgr_pkg::DATA_W'(out_ch.dest_index),
                            fgr_pkg::DATA_W'(want.idx));
          if (out_ch.out_real !== want.re)
            report_mismatch("out_real", out_ch.out_real, want.re);
          if (out_ch.out_imag !== want.im)
            report_mismatch("out_imag", out_ch.out_imag, want.im);
          if (out_ch.grid_done !== want.done)
            report_mismatch("grid_done", fgr_pkg::DATA_W'(out_ch.grid_done),
                            fgr_pkg::DATA_W'(want.done));
        end
        recv_cnt <= recv_cnt + 1;
      end
      if (hold_cnt != 0) begin
        out_ch.ready <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt    <= stall_cnt - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_cnt    <= $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int total, grid, items;
    calm        = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = fgr_pkg::REG_SRC_X;
    cfg_wdata_i = '0;
    for (int i = 0; i < 6; i++) size_reg[i] = 1;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults: every sample lands at index 0 and closes the grid
    push_sample('0, '1);
    push_sample('1, '0);
    wait_idle();

    // truncate x, pad y, zero and saturated z sizes
    write_reg(fgr_pkg::REG_SRC_X, 9'd4);
    write_reg(fgr_pkg::REG_SRC_Y, 9'd3);
    write_reg(fgr_pkg::REG_SRC_Z, 9'd0);
    write_reg(fgr_pkg::REG_DST_X, 9'd2);
    write_reg(fgr_pkg::REG_DST_Y, 9'd5);
    write_reg(fgr_pkg::REG_DST_Z, 9'h1FF);
    end_writes();
    push_items(12);
    push_items(6);
    wait_idle();

    // shrink x mid grid so the x counter sits beyond the size
    write_reg(fgr_pkg::REG_SRC_X, 9'd2);
    write_reg(REG_SPARE_6, 9'h1FF);
    write_reg(REG_SPARE_7, 9'h0AA);
    end_writes();
    push_items(6);
    wait_idle();

    total = 26;
    write_reg(fgr_pkg::REG_SRC_X, 9'd256);
    write_reg(fgr_pkg::REG_SRC_Y, 9'd1);
    write_reg(fgr_pkg::REG_SRC_Z, 9'd1);
    write_reg(fgr_pkg::REG_DST_X, 9'd3);
    write_reg(fgr_pkg::REG_DST_Y, 9'd1);
    write_reg(fgr_pkg::REG_DST_Z, 9'd1);
    end_writes();
    push_items(256);
    total += 256;
    wait_idle();

    while (total < TOTAL_ITEMS) begin
      if (total >= CALM_ITEMS) calm = 1'b1;
      for (int i = 0; i < 6; i++)
        if ($urandom_range(0, 3) != 0) write_reg(fgr_pkg::cfg_reg_e'(i), pick_dim());
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                  fgr_pkg::CFG_W'($urandom));
      end_writes();
      grid = eff_dim(size_reg[fgr_pkg::REG_SRC_X]) * eff_dim(size_reg[fgr_pkg::REG_SRC_Y]) *
             eff_dim(size_reg[fgr_pkg::REG_SRC_Z]);
      if (grid <= 256) begin
        if ($urandom_range(0, 4) == 0) items = $urandom_range(1, grid);
        else items = grid * $urandom_range(1, 2);
      end else begin
        items = $urandom_range(20, 120);
      end
      push_items(items);
      total += items;
      wait_idle();
    end

    repeat (10) @(negedge clk_i);
    if (remap_queue.size() != 0)
      report_mismatch("missing results", fgr_pkg::DATA_W'(remap_queue.size()), '0);
    if (err_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/fgr_pkg.sv
hw/rtl/fgr_in_if.sv
hw/rtl/fgr_out_if.sv
hw/rtl/fgr_axis_map.sv
hw/rtl/fgr_index_pipe.sv
hw/rtl/fft_grid_resize_remap_unit.sv
tb/tb_top.sv
